>>> rtl/ps2dc_pkg.sv
// ps2dc_pkg: shared types and codes for the PS/2 device command and report core.
// Used by every module of the core; depends on nothing.
`timescale 1ns / 1ps

package ps2dc_pkg;

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic [APB_ADDR_W-1:0] REG_MOUSE_MODE = 3'd0;

  localparam int JOB_BYTES = 4;
  localparam int IDX_W = $clog2(JOB_BYTES);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic KIND_COMMAND = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  localparam logic [7:0] CMD_GET_ID = 8'hF2;
  localparam logic [7:0] CMD_READ_ID = 8'hEF;
  localparam logic [7:0] CMD_RESET = 8'hFF;
  localparam logic [7:0] CMD_ECHO = 8'hEE;
  localparam logic [7:0] CMD_ENABLE = 8'hF4;
  localparam logic [7:0] CMD_SET_LEDS = 8'hED;
  localparam logic [7:0] CMD_RESEND = 8'hFE;
  localparam logic [7:0] CMD_DEFAULTS = 8'hF6;
  localparam logic [7:0] CMD_SILENT = 8'hCC;

  localparam logic [7:0] RSP_ACK = 8'hFA;
  localparam logic [7:0] RSP_MOUSE_ID = 8'h00;
  localparam logic [7:0] RSP_KBD_ID0 = 8'hAB;
  localparam logic [7:0] RSP_KBD_ID1 = 8'h83;
  localparam logic [7:0] RSP_ALT_ID0 = 8'hBF;
  localparam logic [7:0] RSP_ALT_ID1 = 8'hB0;
  localparam logic [7:0] RSP_BAT_OK = 8'hAA;
  localparam logic [7:0] WHEEL_UP = 8'hFF;
  localparam logic [7:0] WHEEL_DOWN = 8'h01;
  localparam logic [7:0] WHEEL_NONE = 8'h00;

  typedef struct packed {
    logic              kind;
    logic [7:0]        host_byte;
    logic signed [15:0] move_x;
    logic signed [15:0] move_y;
    logic signed [7:0] wheel;
    logic [2:0]        buttons;
  } in_item_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       tx_parity;
    logic       ack_pulse;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic [JOB_BYTES-1:0][7:0] bytes;
    logic [IDX_W-1:0]          last_idx;
    logic                      ack;
  } job_t;

endpackage

>>> rtl/ps2dc_front.sv
// ps2dc_front: accepts items, decodes host commands, packs mouse reports into jobs.
// Depends on ps2dc_pkg.
`timescale 1ns / 1ps

module ps2dc_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 mouse_mode,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  ps2dc_pkg::in_item_t  in_data,
  output logic                 job_valid,
  input  logic                 job_ready,
  output ps2dc_pkg::job_t      job
);

  logic awaiting_led_argument;
  logic reporting_enabled;
  logic awaiting_led_argument_next;
  logic reporting_enabled_next;
  logic accept;
  logic has_result;

  logic signed [16:0] x_ext;
  logic signed [16:0] y_neg;
  logic [8:0] ux;
  logic [8:0] uy;
  logic [7:0] wheel_byte;

  assign in_ready = job_ready;
  assign accept = in_valid && in_ready;
  assign job_valid = accept && has_result;

  assign x_ext = {in_data.move_x[15], in_data.move_x};
  assign y_neg = -{in_data.move_y[15], in_data.move_y};

  always_comb begin
    if (x_ext > 17'sd255) begin
      ux = 9'h0FF;
    end else if (x_ext < -17'sd255) begin
      ux = 9'h101;
    end else begin
      ux = x_ext[8:0];
    end
    if (y_neg > 17'sd255) begin
      uy = 9'h0FF;
    end else if (y_neg < -17'sd255) begin
      uy = 9'h101;
    end else begin
      uy = y_neg[8:0];
    end
    if (in_data.wheel == 8'sd0) begin
      wheel_byte = ps2dc_pkg::WHEEL_NONE;
    end else if (in_data.wheel[7]) begin
      wheel_byte = ps2dc_pkg::WHEEL_DOWN;
    end else begin
      wheel_byte = ps2dc_pkg::WHEEL_UP;
    end
  end

  always_comb begin
    job = '0;
    has_result = 1'b1;
    awaiting_led_argument_next = awaiting_led_argument;
    reporting_enabled_next = reporting_enabled;
    if (in_data.kind == ps2dc_pkg::KIND_REPORT) begin
      reporting_enabled_next = 1'b1;
      job.bytes[0] = {2'b00, uy[8], ux[8], 1'b1, in_data.buttons};
      job.bytes[1] = ux[7:0];
      job.bytes[2] = uy[7:0];
      job.bytes[3] = wheel_byte;
      job.last_idx = 2'd3;
    end else if (awaiting_led_argument) begin
      awaiting_led_argument_next = 1'b0;
      has_result = 1'b0;
    end else begin
      job.bytes[0] = ps2dc_pkg::RSP_ACK;
      unique case (in_data.host_byte)
        ps2dc_pkg::CMD_GET_ID: begin
          if (mouse_mode) begin
            job.bytes[1] = ps2dc_pkg::RSP_MOUSE_ID;
            job.last_idx = 2'd1;
          end else begin
            job.bytes[1] = ps2dc_pkg::RSP_KBD_ID0;
            job.bytes[2] = ps2dc_pkg::RSP_KBD_ID1;
            job.last_idx = 2'd2;
          end
        end
        ps2dc_pkg::CMD_READ_ID: begin
          job.bytes[1] = ps2dc_pkg::RSP_ALT_ID0;
          job.bytes[2] = ps2dc_pkg::RSP_ALT_ID1;
          job.last_idx = 2'd2;
        end
        ps2dc_pkg::CMD_RESET: begin
          job.bytes[1] = ps2dc_pkg::RSP_BAT_OK;
          job.last_idx = 2'd1;
        end
        ps2dc_pkg::CMD_ECHO: begin
          job.bytes[0] = ps2dc_pkg::CMD_ECHO;
        end
        ps2dc_pkg::CMD_ENABLE: begin
          reporting_enabled_next = 1'b1;
        end
        ps2dc_pkg::CMD_SET_LEDS: begin
          awaiting_led_argument_next = 1'b1;
        end
        ps2dc_pkg::CMD_RESEND, ps2dc_pkg::CMD_DEFAULTS: begin
          job.bytes[0] = 8'h00;
          job.ack = 1'b1;
        end
        ps2dc_pkg::CMD_SILENT: begin
          has_result = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      awaiting_led_argument <= 1'b0;
      reporting_enabled <= 1'b0;
    end else if (accept) begin
      awaiting_led_argument <= awaiting_led_argument_next;
      reporting_enabled <= reporting_enabled_next;
    end
  end

`ifndef SYNTHESIS
  a_report_enables: assert property (@(posedge clk) disable iff (rst)
    accept && in_data.kind == ps2dc_pkg::KIND_REPORT |=> reporting_enabled)
    else $error("report did not enable reporting");

  a_led_arg_swallowed: assert property (@(posedge clk) disable iff (rst)
    accept && in_data.kind == ps2dc_pkg::KIND_COMMAND && awaiting_led_argument
    |-> !job_valid ##1 !awaiting_led_argument)
    else $error("LED argument not swallowed");

  a_ack_single: assert property (@(posedge clk) disable iff (rst)
    job_valid && job.ack |-> job.last_idx == '0 && job.bytes[0] == 8'h00)
    else $error("ack pulse job malformed");
`endif

endmodule

>>> rtl/ps2dc_queue.sv
// ps2dc_queue: short job queue between the front decoder and the byte sender.
// Depends on ps2dc_pkg.
`timescale 1ns / 1ps

module ps2dc_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  ps2dc_pkg::job_t  push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output ps2dc_pkg::job_t  pop_data
);

  ps2dc_pkg::job_t entries [ps2dc_pkg::QUEUE_DEPTH];
  logic [ps2dc_pkg::QPTR_W-1:0] wr_ptr;
  logic [ps2dc_pkg::QPTR_W-1:0] rd_ptr;
  logic [ps2dc_pkg::QCNT_W-1:0] count;
  logic push;
  logic pop;

  assign push_ready = count != ps2dc_pkg::QCNT_W'(ps2dc_pkg::QUEUE_DEPTH);
  assign pop_valid = count != '0;
  assign pop_data = entries[rd_ptr];
  assign push = push_valid && push_ready;
  assign pop = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> rtl/ps2dc_back.sv
// ps2dc_back: sends the bytes of each queued job one per cycle, while out_ready holds, with parity and last mark.
// Depends on ps2dc_pkg.
`timescale 1ns / 1ps

module ps2dc_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 job_valid,
  output logic                 job_ready,
  input  ps2dc_pkg::job_t      job,
  output logic                 out_valid,
  input  logic                 out_ready,
  output ps2dc_pkg::out_item_t out_data
);

  ps2dc_pkg::job_t cur;
  logic cur_valid;
  logic [ps2dc_pkg::IDX_W-1:0] idx;
  logic load;
  logic done_cur;
  logic [7:0] sel_byte;

  assign load = cur_valid && (!out_valid || out_ready);
  assign done_cur = load && idx == cur.last_idx;
  assign job_ready = !cur_valid || done_cur;
  assign sel_byte = cur.bytes[idx];

  always_ff @(posedge clk) begin
    if (job_valid && job_ready) begin
      cur <= job;
    end
    if (load) begin
      out_data.tx_byte <= sel_byte;
      out_data.tx_parity <= cur.ack ? 1'b0 : ~^sel_byte;
      out_data.ack_pulse <= cur.ack;
      out_data.last <= idx == cur.last_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx <= '0;
      out_valid <= 1'b0;
    end else begin
      if (job_valid && job_ready) begin
        cur_valid <= 1'b1;
        idx <= '0;
      end else if (done_cur) begin
        cur_valid <= 1'b0;
      end else if (load) begin
        idx <= idx + 1'b1;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    cur_valid |-> idx <= cur.last_idx)
    else $error("byte index past end of job");

  a_ack_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.ack_pulse |->
    out_data.last && out_data.tx_byte == 8'h00 && !out_data.tx_parity)
    else $error("ack pulse item malformed");

  a_parity: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.ack_pulse |-> out_data.tx_parity == ~^out_data.tx_byte)
    else $error("parity bit wrong");
`endif

endmodule

>>> rtl/ps2_device_command_and_report_core.sv
// ps2_device_command_and_report_core: top level, configuration register and job path.
// Depends on ps2dc_pkg, ps2dc_front, ps2dc_queue, ps2dc_back.
`timescale 1ns / 1ps

// Byte level of a PS/2 device. Each input item is a host command byte or a mouse
// report; the core answers with the bytes the device sends back, each with odd
// parity, or with one ack-pulse item, and marks the final one with last. The front
// takes one item per cycle while the queue has room and decodes it in that cycle;
// a two-job queue feeds the sender, which puts out one result per cycle from its
// output register unless out_ready stalls it. A command yields zero to three
// output items and a mouse report four, so reports are limited by the single
// output byte per cycle. Register 0 (byte address 0) holds mouse_mode, reset to 1.

module ps2_device_command_and_report_core (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  ps2dc_pkg::in_item_t                    in_data,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output ps2dc_pkg::out_item_t                   out_data,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [ps2dc_pkg::APB_ADDR_W-1:0]       paddr,
  input  logic [ps2dc_pkg::APB_DATA_W-1:0]       pwdata,
  output logic [ps2dc_pkg::APB_DATA_W-1:0]       prdata,
  output logic                                   pready
);

  logic mouse_mode;
  logic fq_valid;
  logic fq_ready;
  ps2dc_pkg::job_t fq_job;
  logic qb_valid;
  logic qb_ready;
  ps2dc_pkg::job_t qb_job;

  assign pready = 1'b1;
  assign prdata = (paddr == ps2dc_pkg::REG_MOUSE_MODE) ?
                  {{(ps2dc_pkg::APB_DATA_W-1){1'b0}}, mouse_mode} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      mouse_mode <= 1'b1;
    end else if (psel && penable && pwrite && pready &&
                 paddr == ps2dc_pkg::REG_MOUSE_MODE) begin
      mouse_mode <= pwdata[0];
    end
  end

  ps2dc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .mouse_mode (mouse_mode),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .job_valid  (fq_valid),
    .job_ready  (fq_ready),
    .job        (fq_job)
  );

  ps2dc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_data  (fq_job),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_data   (qb_job)
  );

  ps2dc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (qb_valid),
    .job_ready (qb_ready),
    .job       (qb_job),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
